[src/apcw_pkg.sv]
// Package: shared types, constants and command/status structs for the cost weight block.
package apcw_pkg;

    localparam int unsigned MaxClassesDefault = 16;

    typedef struct packed {
        logic signed [31:0] cost_value;
        logic               last_cost;
    } t_in_req;

    typedef struct packed {
        logic [31:0] weight_value;
        logic [3:0]  class_index;
        logic        last_weight;
    } t_out_req;

    // controller to datapath
    typedef struct packed {
        logic store;      // write incoming cost at count
        logic clr_count;  // clear class count
        logic sort_init;  // start insertion sort, i = 1
        logic sort_cmp;   // compare/shift step
        logic sort_place; // drop pick into slot j
        logic sort_load;  // load pick for current i
        logic acc_init;   // V[0]=0
        logic acc_fetch;  // fetch diff for step k
        logic div_start;  // start divider
        logic div_step;   // one restoring step
        logic acc_add;    // saturating add and store
        logic emit_init;  // start output index
        logic emit_next;  // output taken
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic row_end;    // this input ends the row
        logic sort_more;  // i < n
        logic shift_go;   // j>0 and cost[order[j-1]] > key
        logic acc_more;   // k+1 < n
        logic div_done;
        logic emit_last;  // index is n-1
    } t_sts;

endpackage

[src/apcw_ctrl.sv]
// Controller: state machine sequencing collect, sort, accumulate and emit.
module apcw_ctrl
    import apcw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd,
    output logic  o_in_stall,
    output logic  o_out_valid
);

    typedef enum logic [7:0] {
        S_COLLECT = 8'b0000_0001,
        S_LOAD    = 8'b0000_0010,
        S_CMP     = 8'b0000_0100,
        S_ACCF    = 8'b0000_1000,
        S_DIVS    = 8'b0001_0000,
        S_DIV     = 8'b0010_0000,
        S_ADD     = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_COLLECT: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.row_end) begin
                        o_cmd.sort_init = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (i_sts.sort_more) begin
                    o_cmd.sort_load = 1'b1;
                    n_state = S_CMP;
                end else begin
                    o_cmd.acc_init = 1'b1;
                    n_state = S_ACCF;
                end
            end
            S_CMP: begin
                if (i_sts.shift_go) begin
                    o_cmd.sort_cmp = 1'b1;
                end else begin
                    o_cmd.sort_place = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_ACCF: begin
                if (i_sts.acc_more) begin
                    o_cmd.acc_fetch = 1'b1;
                    n_state = S_DIVS;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ADD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state = S_ACCF;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clr_count = 1'b1;
                        n_state = S_COLLECT;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase
    end

endmodule

[src/apcw_dp.sv]
// Datapath: cost/order/weight stores, sort compare, serial divider, saturating accumulator.
module apcw_dp
    import apcw_pkg::*;
#(
    parameter int unsigned MAX_CLASSES = MaxClassesDefault
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  t_in_req  i_in,
    output t_sts     o_sts,
    output t_out_req o_out
);

    localparam int unsigned IW = $clog2(MAX_CLASSES);
    localparam int unsigned CW = $clog2(MAX_CLASSES + 1);
    localparam int unsigned DW = $clog2(33);

    logic signed [31:0] r_cost  [MAX_CLASSES];
    logic [IW-1:0]      r_order [MAX_CLASSES];
    logic [31:0]        r_wgt   [MAX_CLASSES];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;      // insertion index / step k+1
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_pick;
    logic signed [31:0] r_key;
    logic [31:0]   r_run;
    logic [IW-1:0] r_emit;
    // divider
    logic [31:0]   r_quo;    // dividend shifting into quotient
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_dvs;
    logic [DW-1:0] r_dcnt;
    logic [IW-1:0] r_dst;

    logic [CW-1:0] count_inc;
    logic signed [31:0] prev_cost;
    logic [32:0]   sum;
    logic [CW:0]   rem_sh;

    assign count_inc = r_count + CW'(1);
    assign prev_cost = r_cost[r_order[r_j - IW'(1)]];
    assign rem_sh    = {r_rem, r_quo[31]};
    assign sum       = {1'b0, r_run} + {1'b0, r_quo};

    assign o_sts.row_end   = i_in.last_cost || (count_inc == CW'(MAX_CLASSES));
    assign o_sts.sort_more = r_i < r_count;
    assign o_sts.shift_go  = (r_j != '0) && (prev_cost > r_key);
    assign o_sts.acc_more  = r_i < r_count;
    assign o_sts.div_done  = r_dcnt == DW'(32);
    assign o_sts.emit_last = (CW'(r_emit) + CW'(1)) == r_count;

    assign o_out.weight_value = r_wgt[r_emit];
    assign o_out.class_index  = 4'(r_emit);
    assign o_out.last_weight  = o_sts.emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.store) begin
            r_count <= count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_cost[r_count[IW-1:0]]  <= i_in.cost_value;
            r_order[r_count[IW-1:0]] <= r_count[IW-1:0];
        end
        if (i_cmd.sort_init) begin
            r_i <= CW'(1);
        end
        if (i_cmd.sort_load) begin
            r_pick <= r_order[r_i[IW-1:0]];
            r_key  <= r_cost[r_order[r_i[IW-1:0]]];
            r_j    <= r_i[IW-1:0];
        end
        if (i_cmd.sort_cmp) begin
            r_order[r_j] <= r_order[r_j - IW'(1)];
            r_j <= r_j - IW'(1);
        end
        if (i_cmd.sort_place) begin
            r_order[r_j] <= r_pick;
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.acc_init) begin
            r_run <= '0;
            r_i   <= CW'(1);
            r_wgt[r_order[0]] <= '0;
        end
        if (i_cmd.acc_fetch) begin
            // difference of sorted neighbours, non-negative, fits 32 bits
            r_quo <= 32'(r_cost[r_order[r_i[IW-1:0]]]
                         - r_cost[r_order[r_i[IW-1:0] - IW'(1)]]);
            r_dvs <= r_i;
            r_dst <= r_order[r_i[IW-1:0]];
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            // restoring division, one quotient bit a cycle
            if (rem_sh >= {1'b0, r_dvs}) begin
                r_rem <= CW'(rem_sh - {1'b0, r_dvs});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= CW'(rem_sh);
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_dcnt <= r_dcnt + DW'(1);
        end
        if (i_cmd.acc_add) begin
            r_run <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r_wgt[r_dst] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.emit_init) begin
            r_emit <= '0;
        end else if (i_cmd.emit_next) begin
            r_emit <= r_emit + IW'(1);
        end
    end

endmodule

[src/all_pairs_cost_weight_calc_top.sv]
// Operation: a row of n costs is collected one request a cycle, then sorted by
// insertion, then each of n-1 steps divides the difference of sorted neighbours
// in the restoring divider and adds it into a saturating running sum.
// Weights leave one request a cycle in class order while i_out_stall is low, and
// no request is taken meanwhile. One row is handled at a time.
// Reset: synchronous active-low i_rst_n returns to collecting an empty row.
module all_pairs_cost_weight_calc_top
    import apcw_pkg::*;
#(
    parameter int unsigned MAX_CLASSES = MaxClassesDefault
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    t_cmd cmd;
    t_sts sts;

    // controller: sequences collect, sort, accumulate and emit phases
    apcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // datapath: stores, comparator, serial divider and saturating sum
    apcw_dp #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_req),
        .o_sts   (sts),
        .o_out   (o_out_req)
    );

`ifndef NO_ASSERTIONS
    // input and output requests are never both possible
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall)) else $error("collect and emit overlap");

    // the final weight of a row reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_req.last_weight) |=> !o_in_stall)
        else $error("input not reopened after row");

    // divider and add never run alongside input collection
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_step || cmd.acc_add) |-> o_in_stall) else $error("divider while collecting");
`endif

endmodule
